// File: hw/rtl/rgb_to_hsv_convert_unit_assert.svh
// assertion macros for the rgb to hsv conversion unit
`ifndef RGB_TO_HSV_CONVERT_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_UNIT_ASSERT_SVH

// clocked check, off while reset is low
`define RHC_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rgb to hsv check failed");

// clocked check that also runs during reset
`define RHC_CHECK_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("rgb to hsv check failed");

`endif

// File: hw/rtl/rhc_pkg.sv
// shared types and constants for the rgb to hsv conversion unit
package rhc_pkg;

    localparam int ChanW     = 8;
    localparam int HueW      = 9;
    localparam int PctW      = 7;
    localparam int DividendW = 18;
    localparam int DivisorW  = 9;
    localparam int QuoW      = 9;
    localparam int DivStages = 3;
    localparam int StepBits  = 3;
    localparam int ScaledW   = 15;

    localparam logic [1:0] SecRed   = 2'd0;
    localparam logic [1:0] SecGreen = 2'd1;
    localparam logic [1:0] SecBlue  = 2'd2;

    typedef struct packed {
        logic                  valid;
        logic [DividendW-1:0]  hue_dividend;
        logic [DivisorW-1:0]   hue_divisor;
        logic [DividendW-1:0]  sat_dividend;
        logic [DivisorW-1:0]   sat_divisor;
        logic [ScaledW-1:0]    val_scaled;
    } t_div_req;

endpackage

// File: hw/rtl/rhc_prep.sv
// front stages: channel extremes, then divider operands
module rhc_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [rhc_pkg::ChanW-1:0]     i_red,
    input  logic [rhc_pkg::ChanW-1:0]     i_green,
    input  logic [rhc_pkg::ChanW-1:0]     i_blue,
    output rhc_pkg::t_div_req             o_req
);

    logic [rhc_pkg::ChanW-1:0] n_mx, n_mn;
    logic [1:0]                n_sector;
    logic signed [8:0]         n_diff;

    logic                      r_s1_valid;
    logic [rhc_pkg::ChanW-1:0] r_s1_mx;
    logic [rhc_pkg::ChanW-1:0] r_s1_d;
    logic [1:0]                r_s1_sector;
    logic signed [8:0]         r_s1_diff;

    logic [16:0]               hoff;
    logic signed [17:0]        diff_ext;
    logic signed [17:0]        num;
    rhc_pkg::t_div_req         n_req;
    rhc_pkg::t_div_req         r_req;

    always_comb begin
        n_mx = i_red;
        n_mn = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue > n_mx) n_mx = i_blue;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn) n_mn = i_blue;
        priority if (i_red >= i_green && i_red >= i_blue) begin
            n_sector = rhc_pkg::SecRed;
            n_diff   = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n_sector = rhc_pkg::SecGreen;
            n_diff   = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_sector = rhc_pkg::SecBlue;
            n_diff   = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_take;
        end
        r_s1_mx     <= n_mx;
        r_s1_d      <= n_mx - n_mn;
        r_s1_sector <= n_sector;
        r_s1_diff   <= n_diff;
    end

    always_comb begin
        unique case (r_s1_sector)
            rhc_pkg::SecRed: begin
                hoff = r_s1_diff[8] ? 17'(17'(r_s1_d) * 17'd360) : 17'd0;
            end
            rhc_pkg::SecGreen: begin
                hoff = 17'(17'(r_s1_d) * 17'd120);
            end
            rhc_pkg::SecBlue: begin
                hoff = 17'(17'(r_s1_d) * 17'd240);
            end
            default: begin
                hoff = 17'd0;
            end
        endcase
        diff_ext = 18'(r_s1_diff);
        num      = 18'(diff_ext * 18'sd60) + $signed({1'b0, hoff});

        n_req.valid        = r_s1_valid;
        n_req.hue_dividend = {num[16:0], 1'b0} + 18'(r_s1_d);
        n_req.hue_divisor  = (r_s1_d == '0) ? 9'd2 : {r_s1_d, 1'b0};
        n_req.sat_dividend = 18'(18'(r_s1_d) * 18'd200) + 18'(r_s1_mx);
        n_req.sat_divisor  = (r_s1_mx == '0) ? 9'd2 : {r_s1_mx, 1'b0};
        n_req.val_scaled   = 15'(15'(r_s1_mx) * 15'd100) + 15'd128;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
        end else begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

// File: hw/rtl/rhc_divider.sv
// pipelined restoring divider, three quotient bits per stage
module rhc_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [rhc_pkg::DividendW-1:0]     i_dividend,
    input  logic [rhc_pkg::DivisorW-1:0]      i_divisor,
    output logic                              o_valid,
    output logic [rhc_pkg::QuoW-1:0]          o_quotient
);

    localparam int Last = rhc_pkg::DivStages - 1;

    logic                             r_vld [rhc_pkg::DivStages];
    logic [rhc_pkg::DividendW-1:0]    r_rem [rhc_pkg::DivStages];
    logic [rhc_pkg::DivisorW-1:0]     r_den [rhc_pkg::DivStages];
    logic [rhc_pkg::QuoW-1:0]         r_quo [rhc_pkg::DivStages];

    for (genvar s = 0; s < rhc_pkg::DivStages; s++) begin : g_stage
        logic                             w_vld;
        logic [rhc_pkg::DividendW-1:0]    w_rem;
        logic [rhc_pkg::DivisorW-1:0]     w_den;
        logic [rhc_pkg::QuoW-1:0]         w_quo;
        logic [rhc_pkg::DividendW-1:0]    n_rem;
        logic [rhc_pkg::QuoW-1:0]         n_quo;

        if (s == 0) begin : g_head
            assign w_vld = i_valid;
            assign w_rem = i_dividend;
            assign w_den = i_divisor;
            assign w_quo = '0;
        end else begin : g_body
            assign w_vld = r_vld[s-1];
            assign w_rem = r_rem[s-1];
            assign w_den = r_den[s-1];
            assign w_quo = r_quo[s-1];
        end

        always_comb begin
            logic [rhc_pkg::DividendW-1:0] trial;
            n_rem = w_rem;
            n_quo = w_quo;
            for (int k = 0; k < rhc_pkg::StepBits; k++) begin
                trial = rhc_pkg::DividendW'(w_den)
                        << (rhc_pkg::QuoW - 1 - s * rhc_pkg::StepBits - k);
                if (n_rem >= trial) begin
                    n_rem = n_rem - trial;
                    n_quo = {n_quo[rhc_pkg::QuoW-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[rhc_pkg::QuoW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld;
            end
            r_rem[s] <= n_rem;
            r_den[s] <= w_den;
            r_quo[s] <= n_quo;
        end
    end

    assign o_valid    = r_vld[Last];
    assign o_quotient = r_quo[Last];

endmodule

// File: hw/rtl/rgb_to_hsv_convert_unit.sv
// top level of the rgb to hsv conversion unit
// Takes one rgb word per clock whenever busy is low and returns hue in degrees
// (0..360) with saturation and value in percent (0..100), all rounded half up.
// Every accepted word gives exactly one result on o_done: two operand stages
// followed by a three stage divider that retires three quotient bits per stage,
// with hue and saturation divided in parallel. busy is high while reset is held
// and clears on the clock edge after reset is released;
// results are never held back and must be taken in the cycle o_done is high.
module rgb_to_hsv_convert_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rhc_pkg::ChanW-1:0]     i_red,
    input  logic [rhc_pkg::ChanW-1:0]     i_green,
    input  logic [rhc_pkg::ChanW-1:0]     i_blue,
    output logic                          o_done,
    output logic [rhc_pkg::HueW-1:0]      o_hue,
    output logic [rhc_pkg::PctW-1:0]      o_saturation,
    output logic [rhc_pkg::PctW-1:0]      o_brightness_value
);

    logic                         r_busy;
    rhc_pkg::t_div_req            w_req;
    logic                         w_hue_vld, w_sat_vld;
    logic [rhc_pkg::QuoW-1:0]     w_hue_quo, w_sat_quo;
    logic [22:0]                  w_val_prod;
    logic [rhc_pkg::PctW-1:0]     r_val [rhc_pkg::DivStages];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    rhc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (start && !r_busy),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_req   (w_req)
    );

    rhc_divider u_hue_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_req.valid),
        .i_dividend (w_req.hue_dividend),
        .i_divisor  (w_req.hue_divisor),
        .o_valid    (w_hue_vld),
        .o_quotient (w_hue_quo)
    );

    rhc_divider u_sat_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_req.valid),
        .i_dividend (w_req.sat_dividend),
        .i_divisor  (w_req.sat_divisor),
        .o_valid    (w_sat_vld),
        .o_quotient (w_sat_quo)
    );

    // value by 257/65536 reciprocal of 255
    assign w_val_prod = {w_req.val_scaled, 8'b0} + 23'(w_req.val_scaled);

    always_ff @(posedge i_clk) begin
        r_val[0] <= w_val_prod[22:16];
        for (int i = 1; i < rhc_pkg::DivStages; i++) begin
            r_val[i] <= r_val[i-1];
        end
    end

    assign o_done             = w_hue_vld && w_sat_vld;
    assign o_hue              = w_hue_quo;
    assign o_saturation       = w_sat_quo[rhc_pkg::PctW-1:0];
    assign o_brightness_value = r_val[rhc_pkg::DivStages-1];

endmodule

// File: hw/rtl/rhc_checker.sv
// port level checks for the rgb to hsv conversion unit and its bind
`include "rgb_to_hsv_convert_unit_assert.svh"

module rhc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [rhc_pkg::ChanW-1:0]     i_red,
    input  logic [rhc_pkg::ChanW-1:0]     i_green,
    input  logic [rhc_pkg::ChanW-1:0]     i_blue,
    input  logic                          o_done,
    input  logic [rhc_pkg::HueW-1:0]      o_hue,
    input  logic [rhc_pkg::PctW-1:0]      o_saturation,
    input  logic [rhc_pkg::PctW-1:0]      o_brightness_value
);

    // each accepted word comes back on o_done
    `RHC_CHECK(a_latency, ((start && !busy) |-> ##5 o_done))

    // no result without an accepted word
    `RHC_CHECK(a_no_extra, (o_done |-> $past(start && !busy, 5)))

    // grey input gives zero hue and saturation
    `RHC_CHECK(a_grey, ((start && !busy && i_red == i_green && i_green == i_blue)
        |-> ##5 (o_hue == '0 && o_saturation == '0)))

    `RHC_CHECK(a_range, (o_done |-> (o_hue <= 9'd360 && o_saturation <= 7'd100
        && o_brightness_value <= 7'd100)))

    // busy drops right after reset is released
    `RHC_CHECK_ALWAYS(a_busy_free, ((i_rst_n && $past(i_rst_n)) |-> !busy))

endmodule

bind rgb_to_hsv_convert_unit rhc_checker u_rhc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .i_red              (i_red),
    .i_green            (i_green),
    .i_blue             (i_blue),
    .o_done             (o_done),
    .o_hue              (o_hue),
    .o_saturation       (o_saturation),
    .o_brightness_value (o_brightness_value)
);

// File: bench/tb.sv
// self-checking testbench for the rgb to hsv conversion unit
`timescale 1ns / 100ps

module tb;

    localparam int ResetCycles = 12;
    localparam int IdleLimit   = 2000;
    localparam int DrainCycles = 16;
    localparam int RandomWords = 1950;
    localparam int MaxPrinted  = 60;

    typedef struct packed {
        logic [rhc_pkg::HueW-1:0] hue;
        logic [rhc_pkg::PctW-1:0] sat;
        logic [rhc_pkg::PctW-1:0] val;
    } t_hsv;

    class t_hsv_scoreboard;
        t_hsv hsv_pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function int round_half_up(int num, int den);
            return (2 * num + den) / (2 * den);
        endfunction

        function t_hsv predict_hsv(int r, int g, int b);
            t_hsv res;
            int   mx;
            int   mn;
            int   d;
            int   num;
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            res = '0;
            if (d > 0) begin
                if (mx == r) begin
                    num = 60 * (g - b);
                    if (num < 0) num += 360 * d;
                end else if (mx == g) begin
                    num = 60 * (b - r) + 120 * d;
                end else begin
                    num = 60 * (r - g) + 240 * d;
                end
                if (num < 0) num = 0;
                res.hue = rhc_pkg::HueW'(round_half_up(num, d));
            end
            if (mx > 0) res.sat = rhc_pkg::PctW'(round_half_up(100 * d, mx));
            res.val = rhc_pkg::PctW'(round_half_up(100 * mx, 255));
            return res;
        endfunction

        function void note_pixel(logic [rhc_pkg::ChanW-1:0] r, logic [rhc_pkg::ChanW-1:0] g,
                                 logic [rhc_pkg::ChanW-1:0] b);
            hsv_pending.push_back(predict_hsv(int'(r), int'(g), int'(b)));
        endfunction

        task report(string what, int got, int want);
            if (errors < MaxPrinted)
                $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic [rhc_pkg::HueW-1:0] hue, logic [rhc_pkg::PctW-1:0] sat,
                          logic [rhc_pkg::PctW-1:0] val);
            t_hsv want;
            if (hsv_pending.size() == 0) begin
                report("unexpected word, hue", int'(hue), -1);
            end else begin
                want = hsv_pending.pop_front();
                if (hue !== want.hue) report("hue", int'(hue), int'(want.hue));
                if (sat !== want.sat) report("saturation", int'(sat), int'(want.sat));
                if (val !== want.val) report("value", int'(val), int'(want.val));
            end
        endtask

        function int pending_count();
            return hsv_pending.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [rhc_pkg::ChanW-1:0] i_red;
    logic [rhc_pkg::ChanW-1:0] i_green;
    logic [rhc_pkg::ChanW-1:0] i_blue;
    logic                      o_done;
    logic [rhc_pkg::HueW-1:0]  o_hue;
    logic [rhc_pkg::PctW-1:0]  o_saturation;
    logic [rhc_pkg::PctW-1:0]  o_brightness_value;

    t_hsv_scoreboard sb;
    int              idle_cycles;
    bit              burst_mode;

    rgb_to_hsv_convert_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_red              (i_red),
        .i_green            (i_green),
        .i_blue             (i_blue),
        .o_done             (o_done),
        .o_hue              (o_hue),
        .o_saturation       (o_saturation),
        .o_brightness_value (o_brightness_value)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // monitor: note accepted words and check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_pixel(i_red, i_green, i_blue);
            if (o_done) sb.check_result(o_hue, o_saturation, o_brightness_value);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    function int pick_gap();
        int sel;
        if (burst_mode) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 85) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task send_pixel(logic [rhc_pkg::ChanW-1:0] r, logic [rhc_pkg::ChanW-1:0] g,
                    logic [rhc_pkg::ChanW-1:0] b, int gap);
        @(negedge i_clk);
        start <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        do @(posedge i_clk); while (busy);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_red <= 8'($urandom);
            i_green <= 8'($urandom);
            i_blue <= 8'($urandom);
        end
    endtask

    task send_random_pixel();
        logic [rhc_pkg::ChanW-1:0] r;
        logic [rhc_pkg::ChanW-1:0] g;
        logic [rhc_pkg::ChanW-1:0] b;
        int                        kind;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            g = r;
            b = r;
        end else if (kind < 14) begin
            g = r;
        end else if (kind < 20) begin
            b = r;
        end else if (kind < 26) begin
            b = g;
        end else if (kind < 34) begin
            r = $urandom_range(0, 1) ? 8'hff : 8'h00;
            g = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end else if (kind < 40) begin
            // near-grey and dark words stress the small divisors
            r = 8'($urandom_range(0, 3));
            g = 8'($urandom_range(0, 3));
            b = 8'($urandom_range(0, 3));
        end else if (kind < 46) begin
            r = 8'hff;
            g = 8'($urandom_range(0, 2));
            b = 8'($urandom_range(0, 2));
        end
        send_pixel(r, g, b, pick_gap());
    endtask

    initial begin
        sb = new();
        idle_cycles = 0;
        burst_mode = 1'b0;
        repeat (ResetCycles) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words: extremes, grey, black, ties and hue near a full turn
        send_pixel(8'd0, 8'd0, 8'd0, 0);
        send_pixel(8'd255, 8'd255, 8'd255, 0);
        send_pixel(8'd128, 8'd128, 8'd128, 1);
        send_pixel(8'd255, 8'd0, 8'd0, 0);
        send_pixel(8'd0, 8'd255, 8'd0, 0);
        send_pixel(8'd0, 8'd0, 8'd255, 2);
        send_pixel(8'd255, 8'd255, 8'd0, 0);
        send_pixel(8'd0, 8'd255, 8'd255, 0);
        send_pixel(8'd255, 8'd0, 8'd255, 0);
        send_pixel(8'd255, 8'd0, 8'd1, 3);
        send_pixel(8'd2, 8'd0, 8'd1, 0);
        send_pixel(8'd1, 8'd0, 8'd0, 0);
        send_pixel(8'd0, 8'd0, 8'd1, 0);
        send_pixel(8'd200, 8'd199, 8'd199, 0);
        send_pixel(8'd170, 8'd85, 8'd0, 0);
        send_pixel(8'd0, 8'd1, 8'd1, 5);
        send_pixel(8'd1, 8'd1, 8'd0, 0);
        send_pixel(8'd85, 8'd170, 8'd255, 0);
        send_pixel(8'd254, 8'd255, 8'd253, 0);
        send_pixel(8'd127, 8'd128, 8'd129, 40);

        for (int n = 0; n < RandomWords; n++) begin
            if (n % 150 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            send_random_pixel();
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (sb.pending_count() != 0) sb.report("words left over", sb.pending_count(), 0);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
